// File: hdl/sgi_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection package
// Shared widths, payload structs and stage control types.
// ----------------------------------------------------------------------------
`default_nettype none

package sgi_pkg;

	localparam int CW = 32;          // coordinate width
	localparam int DW = CW + 1;      // endpoint difference width
	localparam int PW = 2 * DW;      // product of two differences
	localparam int NW = PW + 1;      // denominator and numerators
	localparam int RW = NW + 1;      // divider remainder
	localparam int TW = CW + 1;      // position t, 0 .. 1.0 inclusive
	localparam int MW = TW + 1 + DW; // t times direction
	localparam int TOLW = 32;
	localparam logic [TOLW-1:0] TOL_RESET = TOLW'(4295);

	typedef struct packed {
		logic signed [CW-1:0] a_start_x;
		logic signed [CW-1:0] a_start_y;
		logic signed [CW-1:0] a_end_x;
		logic signed [CW-1:0] a_end_y;
		logic signed [CW-1:0] b_start_x;
		logic signed [CW-1:0] b_start_y;
		logic signed [CW-1:0] b_end_x;
		logic signed [CW-1:0] b_end_y;
	} pair_t;

	typedef struct packed {
		logic                 hit;
		logic signed [CW-1:0] cross_x;
		logic signed [CW-1:0] cross_y;
	} result_t;

	typedef struct packed {
		logic valid;
		logic hit;
	} ctl_t;

	typedef struct packed {
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
		logic signed [DW-1:0] dir_x;
		logic signed [DW-1:0] dir_y;
	} geo_t;

	function automatic logic signed [DW-1:0] sext(input logic signed [CW-1:0] v);
		return {v[CW-1], v};
	endfunction

endpackage

`default_nettype wire

// File: hdl/segment_intersection_top.sv
// ----------------------------------------------------------------------------
// Segment intersection top level
// Parametric crossing test of two segments with the crossing point.
// ----------------------------------------------------------------------------
// One segment pair enters per clock while pair_stall is low, and one result
// leaves per pair, in order, after four front stages (differences, products,
// cross terms, sign normalization and range test), 32 divider stages that each
// settle one bit of t, and two stages for the t times direction product and
// rounding. The whole pipeline holds only while a result is waiting under
// stall; then pair_stall is raised. The tolerance register may be written at
// any idle time and applies to pairs transferred after the write.
`default_nettype none

module segment_intersection_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [sgi_pkg::TOLW-1:0]   cfg_wdata,
	input  wire logic                       pair_valid,
	output logic                            pair_stall,
	input  wire sgi_pkg::pair_t             pair,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output sgi_pkg::result_t                result
);
	import sgi_pkg::*;

	logic            en;
	logic [TOLW-1:0] tol_q;
	ctl_t            f_ctl, d_ctl;
	logic [NW-1:0]   f_den, f_na;
	geo_t            f_geo, d_geo;
	logic [TW-1:0]   d_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	assign en         = !(result_valid && result_stall);
	assign pair_stall = !en;

	sgi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pair_valid),
		.pair     (pair),
		.tol      (tol_q),
		.ctl      (f_ctl),
		.den      (f_den),
		.na       (f_na),
		.geo      (f_geo)
	);

	sgi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_ctl (f_ctl),
		.den    (f_den),
		.na     (f_na),
		.in_geo (f_geo),
		.ctl    (d_ctl),
		.t      (d_t),
		.geo    (d_geo)
	);

	sgi_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_ctl    (d_ctl),
		.t         (d_t),
		.in_geo    (d_geo),
		.out_valid (result_valid),
		.result    (result)
	);

endmodule

`default_nettype wire

// File: hdl/sgi_front.sv
// ----------------------------------------------------------------------------
// Segment intersection front end
// Differences, cross products, sign normalization and the crossing test.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_valid,
	input  wire sgi_pkg::pair_t            pair,
	input  wire logic [sgi_pkg::TOLW-1:0]  tol,
	output sgi_pkg::ctl_t                  ctl,
	output logic [sgi_pkg::NW-1:0]         den,
	output logic [sgi_pkg::NW-1:0]         na,
	output sgi_pkg::geo_t                  geo
);
	import sgi_pkg::*;

	logic                 v_s1, v_s2, v_s3;
	logic signed [DW-1:0] ax_s1, ay_s1, bx_s1, by_s1, dx_s1, dy_s1;
	logic signed [CW-1:0] sx_s1, sy_s1;
	logic signed [PW-1:0] axby_s2, bxay_s2, axdy_s2, aydx_s2, bxdy_s2, bydx_s2;
	geo_t                 geo_s2, geo_s3;
	logic [NW-1:0]        den_s3, na_s3, nb_s3;
	ctl_t                 ctl_s4;
	logic [NW-1:0]        den_s4, na_s4;
	geo_t                 geo_s4;

	logic                 neg;
	logic signed [NW-1:0] den_a, na_n, nb_n;
	logic                 hit_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			ctl_s4 <= '0;
		end else if (en) begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			ctl_s4 <= '{valid: v_s3, hit: v_s3 & hit_c};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= sext(pair.a_end_x) - sext(pair.a_start_x);
			ay_s1 <= sext(pair.a_end_y) - sext(pair.a_start_y);
			bx_s1 <= sext(pair.b_end_x) - sext(pair.b_start_x);
			by_s1 <= sext(pair.b_end_y) - sext(pair.b_start_y);
			dx_s1 <= sext(pair.a_start_x) - sext(pair.b_start_x);
			dy_s1 <= sext(pair.a_start_y) - sext(pair.b_start_y);
			sx_s1 <= pair.a_start_x;
			sy_s1 <= pair.a_start_y;

			axby_s2 <= ax_s1 * by_s1;
			bxay_s2 <= bx_s1 * ay_s1;
			axdy_s2 <= ax_s1 * dy_s1;
			aydx_s2 <= ay_s1 * dx_s1;
			bxdy_s2 <= bx_s1 * dy_s1;
			bydx_s2 <= by_s1 * dx_s1;
			geo_s2  <= '{start_x: sx_s1, start_y: sy_s1, dir_x: ax_s1, dir_y: ay_s1};

			den_s3 <= {axby_s2[PW-1], axby_s2} - {bxay_s2[PW-1], bxay_s2};
			nb_s3  <= {axdy_s2[PW-1], axdy_s2} - {aydx_s2[PW-1], aydx_s2};
			na_s3  <= {bxdy_s2[PW-1], bxdy_s2} - {bydx_s2[PW-1], bydx_s2};
			geo_s3 <= geo_s2;

			den_s4 <= den_a;
			na_s4  <= na_n;
			geo_s4 <= geo_s3;
		end
	end

	// A negative denominator flips all three signs so the range test
	// becomes 0 <= numerator <= denominator.
	always_comb begin
		neg   = den_s3[NW-1];
		den_a = neg ? -$signed(den_s3) : $signed(den_s3);
		na_n  = neg ? -$signed(na_s3) : $signed(na_s3);
		nb_n  = neg ? -$signed(nb_s3) : $signed(nb_s3);
		hit_c = (den_a != '0) && (den_a >= $signed({{(NW-TOLW){1'b0}}, tol}))
			&& !na_n[NW-1] && !nb_n[NW-1] && (den_a >= na_n) && (den_a >= nb_n);
	end

	assign ctl = ctl_s4;
	assign den = den_s4;
	assign na  = na_s4;
	assign geo = geo_s4;

endmodule

`default_nettype wire

// File: hdl/sgi_div.sv
// ----------------------------------------------------------------------------
// Segment intersection divider
// Pipelined restoring division, one quotient bit per stage, giving t = NA/D.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire sgi_pkg::ctl_t        in_ctl,
	input  wire logic [sgi_pkg::NW-1:0] den,
	input  wire logic [sgi_pkg::NW-1:0] na,
	input  wire sgi_pkg::geo_t        in_geo,
	output sgi_pkg::ctl_t             ctl,
	output logic [sgi_pkg::TW-1:0]    t,
	output sgi_pkg::geo_t             geo
);
	import sgi_pkg::*;

	ctl_t          ctl_s [CW+1];
	logic [RW-1:0] rem_s [CW+1];
	logic [NW-1:0] den_s [CW+1];
	logic [CW-1:0] q_s   [CW+1];
	logic          full_s[CW+1];
	geo_t          geo_s [CW+1];

	assign ctl_s[0]  = in_ctl;
	assign rem_s[0]  = {1'b0, na};
	assign den_s[0]  = den;
	assign q_s[0]    = '0;
	assign full_s[0] = (na >= den);
	assign geo_s[0]  = in_geo;

	for (genvar i = 0; i < CW; i++) begin : g_step
		logic [RW-1:0] r2;
		logic          ge;

		assign r2 = {rem_s[i][RW-2:0], 1'b0};
		assign ge = r2 >= {1'b0, den_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else if (en) begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? r2 - {1'b0, den_s[i]} : r2;
				den_s[i+1]  <= den_s[i];
				q_s[i+1]    <= {q_s[i][CW-2:0], ge};
				full_s[i+1] <= full_s[i];
				geo_s[i+1]  <= geo_s[i];
			end
		end
	end

	// A numerator equal to the denominator means exactly 1.0.
	assign t   = full_s[CW] ? {1'b1, {CW{1'b0}}} : {1'b0, q_s[CW]};
	assign ctl = ctl_s[CW];
	assign geo = geo_s[CW];

endmodule

`default_nettype wire

// File: hdl/sgi_interp.sv
// ----------------------------------------------------------------------------
// Segment intersection interpolator
// Scales the direction of A by t, rounds, and adds the start point; a miss gives the origin.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_interp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire sgi_pkg::ctl_t        in_ctl,
	input  wire logic [sgi_pkg::TW-1:0] t,
	input  wire sgi_pkg::geo_t        in_geo,
	output logic                      out_valid,
	output sgi_pkg::result_t          result
);
	import sgi_pkg::*;

	localparam logic [MW-1:0] HALF = MW'(1) << (CW - 1);

	ctl_t                 ctl_s1;
	logic signed [MW-1:0] px_s1, py_s1;
	logic signed [CW-1:0] sx_s1, sy_s1;
	logic                 v_s2;
	result_t              res_s2;
	logic [MW-1:0]        rx, ry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			v_s2   <= 1'b0;
		end else if (en) begin
			ctl_s1 <= in_ctl;
			v_s2   <= ctl_s1.valid;
		end
	end

	assign rx = px_s1 + HALF;
	assign ry = py_s1 + HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= $signed({1'b0, t}) * in_geo.dir_x;
			py_s1 <= $signed({1'b0, t}) * in_geo.dir_y;
			sx_s1 <= in_geo.start_x;
			sy_s1 <= in_geo.start_y;
			res_s2.hit     <= ctl_s1.hit;
			res_s2.cross_x <= ctl_s1.hit ? sx_s1 + $signed(rx[CW +: CW]) : '0;
			res_s2.cross_y <= ctl_s1.hit ? sy_s1 + $signed(ry[CW +: CW]) : '0;
		end
	end

	assign out_valid = v_s2;
	assign result    = res_s2;

endmodule

`default_nettype wire

// File: hdl/sgi_checker.sv
// ----------------------------------------------------------------------------
// Segment intersection checker
// Port-level properties of the top level, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             pair_stall,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input wire sgi_pkg::result_t result
);
	import sgi_pkg::*;

	// A result held under stall keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// A miss reports the origin.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.hit |-> result.cross_x == '0 && result.cross_y == '0)
		else $error("miss with nonzero point");

	// Input back-pressure only comes from a blocked output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall |-> result_valid && result_stall)
		else $error("input stalled without output stall");

	// Once the output frees up, the input is taken again at once.
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		!result_stall |-> !pair_stall)
		else $error("input stalled with free output");

endmodule

bind segment_intersection_top sgi_checker u_sgi_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pair_stall   (pair_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire

// File: verif/segment_intersection_top_tb.sv
// ----------------------------------------------------------------------------
// Segment intersection testbench
// Drives segment pairs with random idling on both sides, predicts each
// crossing result with exact wide arithmetic and checks results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sgi_pkg::*;

	localparam int LATENCY = 38;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [TOLW-1:0] cfg_wdata = '0;
	logic pair_valid = 1'b0;
	logic pair_stall;
	pair_t pair = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	logic [TOLW-1:0] tolerance_shadow = TOL_RESET;
	result_t expected_crossings[$];
	int error_count = 0;
	int idle_cycles = 0;
	bit hold_off = 1'b0;
	bit random_stall = 1'b0;

	segment_intersection_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.pair_valid(pair_valid),
		.pair_stall(pair_stall),
		.pair(pair),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Exact crossing prediction; all intermediates fit in 160 signed bits.
	function automatic result_t predict_crossing(pair_t p, logic [TOLW-1:0] tol);
		logic signed [159:0] ax, ay, bx, by, dx, dy, den, na, nb, q, rem, prod;
		logic signed [159:0] px, py;
		result_t r;
		r = '0;
		ax = $signed(p.a_end_x) - $signed(p.a_start_x);
		ay = $signed(p.a_end_y) - $signed(p.a_start_y);
		bx = $signed(p.b_end_x) - $signed(p.b_start_x);
		by = $signed(p.b_end_y) - $signed(p.b_start_y);
		dx = $signed(p.a_start_x) - $signed(p.b_start_x);
		dy = $signed(p.a_start_y) - $signed(p.b_start_y);
		den = ax * by - bx * ay;
		nb = ax * dy - ay * dx;
		na = bx * dy - by * dx;
		if (den < 0) begin
			den = -den;
			na = -na;
			nb = -nb;
		end
		if (den == 0 || den < $signed({128'd0, tol}))
			return r;
		if (na < 0 || nb < 0 || na > den || nb > den)
			return r;
		if (na == den) begin
			q = 160'sd1 <<< 32;
		end else begin
			q = 0;
			rem = na;
			for (int i = 0; i < 32; i++) begin
				rem = rem <<< 1;
				q = q <<< 1;
				if (rem >= den) begin
					rem = rem - den;
					q = q + 1;
				end
			end
		end
		prod = q * ax + (160'sd1 <<< 31);
		px = $signed(p.a_start_x) + (prod >>> 32);
		prod = q * ay + (160'sd1 <<< 31);
		py = $signed(p.a_start_y) + (prod >>> 32);
		r.hit = 1'b1;
		r.cross_x = px[CW-1:0];
		r.cross_y = py[CW-1:0];
		return r;
	endfunction

	// Valid stays high between back-to-back transfers; it drops only for an
	// idle gap or when the pipeline is drained.
	task automatic send_pair(pair_t p);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			pair_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pair_valid <= 1'b1;
		pair <= p;
		@(posedge clk);
		while (pair_stall) @(posedge clk);
		expected_crossings.push_back(predict_crossing(p, tolerance_shadow));
	endtask

	task automatic drain_results();
		pair_valid <= 1'b0;
		while (expected_crossings.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [TOLW-1:0] value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tolerance_shadow = value;
	endtask

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return CW'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
			2: return CW'($signed($urandom_range(0, 64)) - 32);
			default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
		endcase
	endfunction

	// Builds a pair that crosses near a chosen point so many items hit.
	function automatic pair_t crossing_pair();
		pair_t p;
		logic signed [CW-1:0] cx, cy;
		int span;
		span = 1 << $urandom_range(4, 28);
		cx = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
		cy = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
		p.a_start_x = cx - $signed($urandom_range(0, span));
		p.a_start_y = cy - $signed($urandom_range(0, span));
		p.a_end_x = cx + $signed($urandom_range(0, span));
		p.a_end_y = cy + $signed($urandom_range(0, span));
		p.b_start_x = cx + $signed($urandom_range(0, span));
		p.b_start_y = cy - $signed($urandom_range(0, span));
		p.b_end_x = cx - $signed($urandom_range(0, span));
		p.b_end_y = cy + $signed($urandom_range(0, span));
		return p;
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		if ($urandom_range(0, 3) != 0)
			return crossing_pair();
		p.a_start_x = rand_coord();
		p.a_start_y = rand_coord();
		p.a_end_x = rand_coord();
		p.a_end_y = rand_coord();
		p.b_start_x = rand_coord();
		p.b_start_y = rand_coord();
		p.b_end_x = rand_coord();
		p.b_end_y = rand_coord();
		return p;
	endfunction

	function automatic pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
			int bx0, int by0, int bx1, int by1);
		pair_t p;
		p.a_start_x = ax0;
		p.a_start_y = ay0;
		p.a_end_x = ax1;
		p.a_end_y = ay1;
		p.b_start_x = bx0;
		p.b_start_y = by0;
		p.b_end_x = bx1;
		p.b_end_y = by1;
		return p;
	endfunction

	task automatic test_directed();
		localparam int ONE = 1 << 16;
		int mx, mn;
		mx = 32'h7fff_ffff;
		mn = 32'h8000_0000;
		// A plain cross, an endpoint touch at both ends, and a T junction.
		send_pair(make_pair(0, 0, 2 * ONE, 2 * ONE, 0, 2 * ONE, 2 * ONE, 0));
		send_pair(make_pair(0, 0, ONE, 0, 0, 0, 0, ONE));
		send_pair(make_pair(0, 0, ONE, 0, ONE, 0, ONE, ONE));
		send_pair(make_pair(0, 0, 2 * ONE, 0, ONE, 0, ONE, ONE));
		// Parallel, collinear overlapping, degenerate and missing pairs.
		send_pair(make_pair(0, 0, ONE, 0, 0, ONE, ONE, ONE));
		send_pair(make_pair(0, 0, 2 * ONE, 0, ONE, 0, 3 * ONE, 0));
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
		send_pair(make_pair(0, 0, ONE, ONE, 3 * ONE, 0, 3 * ONE, ONE));
		// Tiny denominators above the reset tolerance.
		send_pair(make_pair(0, 0, 1, 0, 0, -4000, 1, 4000));
		send_pair(make_pair(0, 0, 1, 0, 0, -5000, 1, 5000));
		// Field extremes.
		send_pair(make_pair(mn, mn, mx, mx, mn, mx, mx, mn));
		send_pair(make_pair(mx, mn, mn, mx, mx, mx, mn, mn));
		send_pair(make_pair(mx, mx, mx, mx, mn, mn, mn, mn));
		send_pair(make_pair(mn, 0, mx, 0, 0, mn, 0, mx));
		send_pair(make_pair(-1, -1, 1, 1, -1, 1, 1, -1));
		send_pair(make_pair(mx, 0, mn, 0, 0, mx, 0, mn));
	endtask

	task automatic test_tolerance_settings();
		write_tolerance('0);
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
		send_pair(make_pair(0, 0, 1, 0, 0, -1, 1, 1));
		repeat (40) send_pair(random_pair());
		write_tolerance('1);
		send_pair(make_pair(0, 0, 1 << 20, 1 << 20, 0, 1 << 20, 1 << 20, 0));
		send_pair(make_pair(0, 0, 1 << 30, 1 << 30, 0, 1 << 30, 1 << 30, 0));
		repeat (40) send_pair(random_pair());
		write_tolerance(32'h0001_0000);
		repeat (40) send_pair(random_pair());
		write_tolerance(TOL_RESET);
	endtask

	// The caller drains afterwards, which also drops valid.
	task automatic test_random_stream();
		random_stall = 1'b1;
		repeat (1300) send_pair(random_pair());
		random_stall = 1'b0;
		repeat (50) begin
			pair_valid <= 1'b1;
			pair <= random_pair();
			@(posedge clk);
			while (pair_stall) @(posedge clk);
			expected_crossings.push_back(predict_crossing(pair, tolerance_shadow));
		end
	endtask

	task automatic test_backpressure();
		// Sender pauses until everything is back, then keeps offering while
		// the receiver holds off long enough for the pipeline to fill.
		drain_results();
		hold_off = 1'b1;
		repeat (100) send_pair(random_pair());
		drain_results();
	endtask

	// Receiver stall generation.
	always @(posedge clk) begin
		int hold_count;
		int stall_left;
		if (hold_off) begin
			result_stall <= 1'b1;
			hold_count++;
			if (hold_count >= 200) begin
				hold_off <= 1'b0;
				hold_count = 0;
			end
		end else if (random_stall) begin
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				stall_left = $urandom_range(0, 4);
			end
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Result checking.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_crossings.size() == 0) begin
				$display("%0t: unexpected result %p", $time, result);
				error_count++;
			end else begin
				want = expected_crossings.pop_front();
				if (result.hit !== want.hit) begin
					$display("%0t: hit expected %0b actual %0b", $time, want.hit, result.hit);
					error_count++;
				end
				if (result.cross_x !== want.cross_x) begin
					$display("%0t: cross_x expected %h actual %h", $time, want.cross_x,
						result.cross_x);
					error_count++;
				end
				if (result.cross_y !== want.cross_y) begin
					$display("%0t: cross_y expected %h actual %h", $time, want.cross_y,
						result.cross_y);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((pair_valid && !pair_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_tolerance_settings();
		test_backpressure();
		test_random_stream();
		drain_results();
		if (error_count == 0 && expected_crossings.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
